[rtl/grouped_chaser_step_generator_unit_assert.svh]
// Assertion macros used by the chaser step generator controller.
`ifndef GROUPED_CHASER_STEP_GENERATOR_UNIT_ASSERT_SVH
`define GROUPED_CHASER_STEP_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define GCSG_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define GCSG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gcsg_pkg.sv]
// Shared types, constants and register codes of the chaser step generator.
package gcsg_pkg;

    // Defaults of the top-level size parameters
    localparam int MAX_FIXTURES_DEF = 64;
    localparam int MAX_GROUPS_DEF   = 16;

    // Field and register widths
    localparam int MASK_W      = 64;
    localparam int COUNT_W     = 7;
    localparam int GROUP_CFG_W = 5;
    localparam int SIZE_W      = 7;
    localparam int MODE_W      = 2;
    localparam int PARITY_W    = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 7;
    localparam int STEP_W      = 7;
    localparam int SEQ_W       = 8;
    localparam int POS_W       = 12;
    localparam int SEQ_NUM_W   = 10;

    // Stream packing
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_PAD_W   = OUT_TDATA_W - MASK_W - STEP_W;

    // Iterative divider
    localparam int DIV_NUM_W = 8;
    localparam int DIV_DEN_W = 7;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // Register indexes on the configuration channel
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_FIXTURE_COUNT = 3'd0;
    localparam cfg_index_t REG_GROUP_COUNT   = 3'd1;
    localparam cfg_index_t REG_WINDOW_SIZE   = 3'd2;
    localparam cfg_index_t REG_MOVE_SIZE     = 3'd3;
    localparam cfg_index_t REG_MOTION_MODE   = 3'd4;
    localparam cfg_index_t REG_PARITY_BLOCK  = 3'd5;
    localparam cfg_index_t NUM_REGS          = 3'd6;

    // Motion modes; code 3 runs as forward
    typedef logic [MODE_W-1:0] mode_t;
    localparam mode_t MODE_FORWARD  = 2'd0;
    localparam mode_t MODE_BACKWARD = 2'd1;
    localparam mode_t MODE_PINGPONG = 2'd2;

    // Register values after reset
    localparam logic [COUNT_W-1:0]     RST_FIXTURE_COUNT = 7'd18;
    localparam logic [GROUP_CFG_W-1:0] RST_GROUP_COUNT   = 5'd1;
    localparam logic [SIZE_W-1:0]      RST_WINDOW_SIZE   = 7'd1;
    localparam logic [SIZE_W-1:0]      RST_MOVE_SIZE     = 7'd1;
    localparam mode_t                  RST_MOTION_MODE   = MODE_FORWARD;
    localparam logic [PARITY_W-1:0]    RST_PARITY_BLOCK  = 5'd0;

    // Controller to datapath commands
    typedef struct packed {
        logic cfg_write;
        logic div_seg;
        logic div_seq;
        logic load_seg;
        logic load_seq;
        logic reload_pos;
        logic scan_init;
        logic scan_step;
        logic emit;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic scan_last;
    } status_t;

endpackage

[rtl/gcsg_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned 8 by 7 bits.
module gcsg_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [gcsg_pkg::DIV_NUM_W-1:0] num,
    input  logic [gcsg_pkg::DIV_DEN_W-1:0] den,
    output logic                           done,
    output logic [gcsg_pkg::DIV_NUM_W-1:0] quot
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [gcsg_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [gcsg_pkg::DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [gcsg_pkg::DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [gcsg_pkg::DIV_DEN_W-1:0] den_reg, den_next;

    logic [gcsg_pkg::DIV_DEN_W:0]   rem_shift;
    logic [gcsg_pkg::DIV_DEN_W+1:0] diff;
    logic                           fits;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[gcsg_pkg::DIV_NUM_W-1]};
        diff      = {1'b0, rem_shift} - {2'b00, den_reg};
        fits      = ~diff[gcsg_pkg::DIV_DEN_W+1];
    end

    // Iteration control and operand shift
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = gcsg_pkg::DIV_CNT_W'(gcsg_pkg::DIV_NUM_W - 1);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[gcsg_pkg::DIV_DEN_W-1:0]
                            : rem_shift[gcsg_pkg::DIV_DEN_W-1:0];
            quo_next = {quo_reg[gcsg_pkg::DIV_NUM_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

[rtl/gcsg_datapath.sv]
// Datapath: configuration, segment math, window positions, mask scan and output register.
module gcsg_datapath
#(
    parameter int MAX_FIXTURES = gcsg_pkg::MAX_FIXTURES_DEF,
    parameter int MAX_GROUPS   = gcsg_pkg::MAX_GROUPS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  gcsg_pkg::cmd_t                   cmd,
    output gcsg_pkg::status_t                status,
    input  logic [gcsg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gcsg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             restart,
    output logic [gcsg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast
);

    localparam int GRP_W = $clog2(MAX_GROUPS + 1);
    localparam int CMP_W = (GRP_W > gcsg_pkg::GROUP_CFG_W) ? GRP_W : gcsg_pkg::GROUP_CFG_W;

    // Configuration registers
    logic [gcsg_pkg::COUNT_W-1:0]     fix_reg;
    logic [gcsg_pkg::GROUP_CFG_W-1:0] grp_reg;
    logic [gcsg_pkg::SIZE_W-1:0]      win_reg;
    logic [gcsg_pkg::SIZE_W-1:0]      move_reg;
    gcsg_pkg::mode_t                  mode_reg;
    logic [gcsg_pkg::PARITY_W-1:0]    par_reg;

    // Effective (clamped) settings
    logic [gcsg_pkg::COUNT_W-1:0] n_eff;
    logic [CMP_W-1:0]             ng_ext;
    logic [GRP_W-1:0]             ng_eff;
    logic [gcsg_pkg::SIZE_W-1:0]  mv_eff;

    // Sequence geometry
    logic [gcsg_pkg::COUNT_W-1:0]        seg_reg, seg_next;
    logic [gcsg_pkg::SEQ_W-1:0]          seq_reg, seq_next;
    logic signed [gcsg_pkg::SEQ_NUM_W-1:0] seq_num;
    logic [gcsg_pkg::DIV_NUM_W-1:0]      k_val;

    // Divider hookup
    logic [gcsg_pkg::DIV_NUM_W-1:0] div_num;
    logic [gcsg_pkg::DIV_DEN_W-1:0] div_den;
    logic [gcsg_pkg::DIV_NUM_W-1:0] div_quot;
    logic                           div_done;

    // Shared displacement from the initial positions and the ping-pong flip
    logic signed [gcsg_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                              flip_reg, flip_next;
    logic [gcsg_pkg::STEP_W-1:0]       step_reg, step_next;

    // Group scan
    logic [GRP_W-1:0]                grp_left_reg, grp_left_next;
    logic [gcsg_pkg::COUNT_W-1:0]    start_reg, start_next;
    logic [gcsg_pkg::PARITY_W-1:0]   par_cnt_reg, par_cnt_next;
    logic                            par_bit_reg, par_bit_next;
    logic [MAX_FIXTURES-1:0]         acc_reg, acc_next;

    // Output register
    logic [MAX_FIXTURES-1:0]     out_mask_reg;
    logic [gcsg_pkg::STEP_W-1:0] out_step_reg;
    logic                        out_last_reg;

    // Window arithmetic
    logic signed [gcsg_pkg::POS_W-1:0] span, mv_s, win_s, n_s;
    logic signed [gcsg_pkg::POS_W-1:0] head, head_end, ipos;
    logic signed [gcsg_pkg::POS_W-1:0] step_amt, p_try;
    logic                              grp_neg, bounce, last;
    logic [MAX_FIXTURES-1:0]           grp_mask;
    logic                              reload;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fix_reg  <= gcsg_pkg::RST_FIXTURE_COUNT;
            grp_reg  <= gcsg_pkg::RST_GROUP_COUNT;
            win_reg  <= gcsg_pkg::RST_WINDOW_SIZE;
            move_reg <= gcsg_pkg::RST_MOVE_SIZE;
            mode_reg <= gcsg_pkg::RST_MOTION_MODE;
            par_reg  <= gcsg_pkg::RST_PARITY_BLOCK;
        end
        else if (cmd.cfg_write)
        begin
            unique case (cfg_index)
                gcsg_pkg::REG_FIXTURE_COUNT: fix_reg  <= cfg_data[gcsg_pkg::COUNT_W-1:0];
                gcsg_pkg::REG_GROUP_COUNT:   grp_reg  <= cfg_data[gcsg_pkg::GROUP_CFG_W-1:0];
                gcsg_pkg::REG_WINDOW_SIZE:   win_reg  <= cfg_data[gcsg_pkg::SIZE_W-1:0];
                gcsg_pkg::REG_MOVE_SIZE:     move_reg <= cfg_data[gcsg_pkg::SIZE_W-1:0];
                gcsg_pkg::REG_MOTION_MODE:   mode_reg <= cfg_data[gcsg_pkg::MODE_W-1:0];
                gcsg_pkg::REG_PARITY_BLOCK:  par_reg  <= cfg_data[gcsg_pkg::PARITY_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the settings to their legal ranges
    always_comb
    begin
        n_eff  = (fix_reg > gcsg_pkg::COUNT_W'(MAX_FIXTURES))
               ? gcsg_pkg::COUNT_W'(MAX_FIXTURES) : fix_reg;
        ng_ext = CMP_W'(grp_reg);
        if (ng_ext == '0)
            ng_ext = CMP_W'(1);
        else if (ng_ext > CMP_W'(MAX_GROUPS))
            ng_ext = CMP_W'(MAX_GROUPS);
        ng_eff = ng_ext[GRP_W-1:0];
        mv_eff = (move_reg == '0) ? gcsg_pkg::SIZE_W'(1) : move_reg;
    end

    // Division operands: fixtures over groups, then the step count
    always_comb
    begin
        seq_num = $signed(gcsg_pkg::SEQ_NUM_W'(seg_reg))
                - $signed(gcsg_pkg::SEQ_NUM_W'(win_reg))
                + $signed(gcsg_pkg::SEQ_NUM_W'(mv_eff))
                - $signed(gcsg_pkg::SEQ_NUM_W'(1));
        if (cmd.div_seg)
        begin
            div_num = gcsg_pkg::DIV_NUM_W'(n_eff);
            div_den = gcsg_pkg::DIV_DEN_W'(ng_eff);
        end
        else
        begin
            div_num = seq_num[gcsg_pkg::DIV_NUM_W-1:0];
            div_den = mv_eff;
        end
    end

    gcsg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_seg | cmd.div_seq),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Segment length and sequence length from the quotients
    always_comb
    begin
        seg_next = seg_reg;
        seq_next = seq_reg;
        // a numerator of zero or less gives no full move
        k_val = (seq_num > 0) ? div_quot : '0;
        if (cmd.load_seg)
            seg_next = (div_quot == '0) ? gcsg_pkg::COUNT_W'(1)
                                        : div_quot[gcsg_pkg::COUNT_W-1:0];
        if (cmd.load_seq)
        begin
            if (mode_reg == gcsg_pkg::MODE_PINGPONG)
                seq_next = (k_val == '0) ? gcsg_pkg::SEQ_W'(1)
                                         : gcsg_pkg::SEQ_W'({k_val, 1'b0});
            else
                seq_next = gcsg_pkg::SEQ_W'(k_val) + gcsg_pkg::SEQ_W'(1);
        end
    end

    // Window of the group under scan; backward groups mirror the displacement
    always_comb
    begin
        span     = $signed(gcsg_pkg::POS_W'(seg_reg)) - $signed(gcsg_pkg::POS_W'(win_reg));
        win_s    = $signed(gcsg_pkg::POS_W'(win_reg));
        n_s      = $signed(gcsg_pkg::POS_W'(n_eff));
        mv_s     = $signed(gcsg_pkg::POS_W'(mv_eff));
        grp_neg  = (mode_reg == gcsg_pkg::MODE_BACKWARD) ^ par_bit_reg;
        head     = $signed(gcsg_pkg::POS_W'(start_reg)) + (grp_neg ? span - pos_reg : pos_reg);
        head_end = head + win_s;
        for (int i = 0; i < MAX_FIXTURES; i++)
        begin
            ipos        = $signed(gcsg_pkg::POS_W'(i));
            grp_mask[i] = (ipos >= head) && (ipos < head_end) && (ipos < n_s);
        end
    end

    // Next displacement; ping-pong reverses all groups when one would leave
    always_comb
    begin
        step_amt = flip_reg ? -mv_s : mv_s;
        p_try    = pos_reg + step_amt;
        bounce   = (mode_reg == gcsg_pkg::MODE_PINGPONG) && ((p_try < 0) || (p_try > span));
        last     = ({1'b0, step_reg} == (seq_reg - gcsg_pkg::SEQ_W'(1)));
        reload   = cmd.reload_pos || (cmd.scan_init && restart) || (cmd.emit && last);

        pos_next  = pos_reg;
        flip_next = flip_reg;
        step_next = step_reg;
        priority if (reload)
        begin
            pos_next  = '0;
            flip_next = 1'b0;
            step_next = '0;
        end
        else if (cmd.emit)
        begin
            if (bounce)
            begin
                flip_next = ~flip_reg;
                pos_next  = pos_reg - step_amt;
            end
            else
            begin
                pos_next = p_try;
            end
            step_next = step_reg + 1'b1;
        end
    end

    // Group scan: one group per cycle into the mask accumulator
    always_comb
    begin
        grp_left_next = grp_left_reg;
        start_next    = start_reg;
        par_cnt_next  = par_cnt_reg;
        par_bit_next  = par_bit_reg;
        acc_next      = acc_reg;
        if (cmd.scan_init)
        begin
            grp_left_next = ng_eff;
            start_next    = '0;
            par_cnt_next  = '0;
            par_bit_next  = 1'b0;
            acc_next      = '0;
        end
        else if (cmd.scan_step)
        begin
            acc_next      = acc_reg | grp_mask;
            start_next    = start_reg + seg_reg;
            grp_left_next = grp_left_reg - 1'b1;
            if (par_reg != '0)
            begin
                if (par_cnt_reg == par_reg - 1'b1)
                begin
                    par_cnt_next = '0;
                    par_bit_next = ~par_bit_reg;
                end
                else
                begin
                    par_cnt_next = par_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg      <= gcsg_pkg::COUNT_W'(1);
            seq_reg      <= gcsg_pkg::SEQ_W'(1);
            pos_reg      <= '0;
            flip_reg     <= 1'b0;
            step_reg     <= '0;
            grp_left_reg <= '0;
            par_cnt_reg  <= '0;
            par_bit_reg  <= 1'b0;
        end
        else
        begin
            seg_reg      <= seg_next;
            seq_reg      <= seq_next;
            pos_reg      <= pos_next;
            flip_reg     <= flip_next;
            step_reg     <= step_next;
            grp_left_reg <= grp_left_next;
            par_cnt_reg  <= par_cnt_next;
            par_bit_reg  <= par_bit_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        acc_reg   <= acc_next;
        if (cmd.emit)
        begin
            out_mask_reg <= acc_reg;
            out_step_reg <= step_reg;
            out_last_reg <= last;
        end
    end

    assign status.div_done  = div_done;
    assign status.scan_last = (grp_left_reg == GRP_W'(1));

    assign m_axis_tdata = {{gcsg_pkg::OUT_PAD_W{1'b0}}, out_step_reg,
                           gcsg_pkg::MASK_W'(out_mask_reg)};
    assign m_axis_tlast = out_last_reg;

endmodule

[rtl/gcsg_ctrl.sv]
// Controller: sequences reloads, group scans and result hand-off.
`include "grouped_chaser_step_generator_unit_assert.svh"

module gcsg_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gcsg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  gcsg_pkg::status_t              status,
    output gcsg_pkg::cmd_t                 cmd
);

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] ST_IDLE      = 3'd0;
    localparam logic [STATE_W-1:0] ST_SEG_START = 3'd1;
    localparam logic [STATE_W-1:0] ST_SEG_WAIT  = 3'd2;
    localparam logic [STATE_W-1:0] ST_SEQ_START = 3'd3;
    localparam logic [STATE_W-1:0] ST_SEQ_WAIT  = 3'd4;
    localparam logic [STATE_W-1:0] ST_SCAN      = 3'd5;
    localparam logic [STATE_W-1:0] ST_EMIT      = 3'd6;

    logic [STATE_W-1:0] state_reg, state_next;
    logic               m_valid_reg, m_valid_next;

    // Handshakes open only between transactions; configuration goes first
    assign cfg_ready     = (state_reg == ST_IDLE);
    assign s_axis_tready = (state_reg == ST_IDLE) && !cfg_valid;
    assign m_axis_tvalid = m_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_axis_tready;
        unique case (state_reg)
            ST_SEG_START:
            begin
                cmd.div_seg = 1'b1;
                state_next  = ST_SEG_WAIT;
            end
            ST_SEG_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.load_seg = 1'b1;
                    state_next   = ST_SEQ_START;
                end
            end
            ST_SEQ_START:
            begin
                cmd.div_seq = 1'b1;
                state_next  = ST_SEQ_WAIT;
            end
            ST_SEQ_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.load_seq   = 1'b1;
                    cmd.reload_pos = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    cmd.cfg_write = 1'b1;
                    if (cfg_index < gcsg_pkg::NUM_REGS)
                        state_next = ST_SEG_START;
                end
                else if (s_axis_tvalid)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // wait for the output register to be free
                if (!m_valid_reg || m_axis_tready)
                begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_SEG_START;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_SEG_START;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // A stalled result keeps the controller parked with the result shown
    `GCSG_ASSERT_NEXT(a_emit_stall_holds, (state_reg == ST_EMIT) && m_valid_reg && !m_axis_tready, (state_reg == ST_EMIT) && m_valid_reg, "emit left while output stalled")
    // Divider completions are only seen while the controller waits for them
    `GCSG_ASSERT_IMPLY(a_div_done_waited, status.div_done, (state_reg == ST_SEG_WAIT) || (state_reg == ST_SEQ_WAIT), "divider result arrived unexpectedly")
    // A new result only appears after an emit
    `GCSG_ASSERT_IMPLY(a_valid_from_emit, $rose(m_axis_tvalid), $past(state_reg) == ST_EMIT, "output valid rose outside emit")

endmodule

[rtl/grouped_chaser_step_generator_unit.sv]
// Top level of the grouped light-chaser step generator.
// Each transaction on the s_axis side is one chaser tick and returns one
// transaction on the m_axis side with the lit-fixture mask, the step index and
// tlast on the final step before the sequence wraps. A tick is accepted, then
// the window mask is built group by group (a single window unit walks the
// groups), then the output register is loaded; a result that waits on
// m_axis_tready does not block the next tick from being accepted. Restart
// costs nothing extra. After reset and after every configuration write to a
// known register the block recomputes the segment and step counts with a
// bit-serial divider, during which s_axis_tready and cfg_ready stay low;
// writes to unknown indexes are taken and ignored.
module grouped_chaser_step_generator_unit
#(
    parameter int MAX_FIXTURES = gcsg_pkg::MAX_FIXTURES_DEF,
    parameter int MAX_GROUPS   = gcsg_pkg::MAX_GROUPS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gcsg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gcsg_pkg::CFG_DATA_W-1:0]  cfg_data,
    // tick input
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [gcsg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [0] restart, [7:1] zero
    // step output
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [gcsg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [63:0] lit_mask, [70:64] step_index, [71] zero
    output logic                             m_axis_tlast   // last_step
);

    gcsg_pkg::cmd_t    cmd;
    gcsg_pkg::status_t status;

    gcsg_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    gcsg_datapath
    #(
        .MAX_FIXTURES (MAX_FIXTURES),
        .MAX_GROUPS   (MAX_GROUPS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .restart      (s_axis_tdata[0]),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

endmodule

[verif/grouped_chaser_step_generator_unit_tb.sv]
// Self-checking testbench for the grouped light-chaser step generator.
`timescale 1ns / 1ps

module grouped_chaser_step_generator_unit_tb;

    localparam int MAX_FIX      = gcsg_pkg::MAX_FIXTURES_DEF;
    localparam int MAX_GRP      = gcsg_pkg::MAX_GROUPS_DEF;
    localparam int RANDOM_TICKS = 850;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;

    // One emitted chaser step
    typedef struct packed {
        logic [gcsg_pkg::MASK_W-1:0] mask;
        logic [gcsg_pkg::STEP_W-1:0] step;
        logic                        last;
    } chaser_step_t;

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [gcsg_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [gcsg_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [gcsg_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [gcsg_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tlast;

    // Stimulus and scoreboard state
    bit           tick_queue[$];
    chaser_step_t step_expected[$];
    int           ticks_pushed = 0;
    int           ticks_accepted = 0;
    int           mismatch_count = 0;
    int           gap_pct = 10;
    int           hold_requests = 0;
    int           holds_served = 0;
    int           hold_left = 0;
    int           cycle_count = 0;

    // Predictor copy of the registers
    logic [gcsg_pkg::COUNT_W-1:0]     fixture_count_r = gcsg_pkg::RST_FIXTURE_COUNT;
    logic [gcsg_pkg::GROUP_CFG_W-1:0] group_count_r   = gcsg_pkg::RST_GROUP_COUNT;
    logic [gcsg_pkg::SIZE_W-1:0]      window_r        = gcsg_pkg::RST_WINDOW_SIZE;
    logic [gcsg_pkg::SIZE_W-1:0]      move_r          = gcsg_pkg::RST_MOVE_SIZE;
    gcsg_pkg::mode_t                  mode_r          = gcsg_pkg::RST_MOTION_MODE;
    logic [gcsg_pkg::PARITY_W-1:0]    parity_r        = gcsg_pkg::RST_PARITY_BLOCK;

    // Predictor copy of the chaser state
    int head_pos[MAX_GRP];
    int head_dir[MAX_GRP];
    int seg_base[MAX_GRP];
    int seg_len;
    int seq_len;
    int step_cnt;

    grouped_chaser_step_generator_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Effective register values after clamping
    function automatic int fixtures_eff();
        return (int'(fixture_count_r) > MAX_FIX) ? MAX_FIX : int'(fixture_count_r);
    endfunction

    function automatic int groups_eff();
        int g;
        g = int'(group_count_r);
        if (g < 1)
            g = 1;
        return (g > MAX_GRP) ? MAX_GRP : g;
    endfunction

    function automatic int move_eff();
        return (move_r == '0) ? 1 : int'(move_r);
    endfunction

    // Initial window positions, segment and sequence lengths
    function automatic void reload_windows();
        int n, ng, win, mv, pb, base, sgn, k, s;
        n    = fixtures_eff();
        ng   = groups_eff();
        win  = int'(window_r);
        mv   = move_eff();
        pb   = int'(parity_r);
        base = (mode_r == gcsg_pkg::MODE_BACKWARD) ? -1 : 1;
        seg_len = n / ng;
        if (seg_len < 1)
            seg_len = 1;
        for (int g = 0; g < ng; g++)
        begin
            sgn = (pb != 0 && ((g / pb) % 2) != 0) ? -1 : 1;
            seg_base[g] = g * seg_len;
            head_dir[g] = base * sgn;
            head_pos[g] = (head_dir[g] > 0) ? seg_base[g] : seg_base[g] + seg_len - win;
        end
        k = (seg_len - win + mv - 1) / mv;
        s = (mode_r == gcsg_pkg::MODE_PINGPONG) ? 2 * k : k + 1;
        seq_len  = (s < 1) ? 1 : s;
        step_cnt = 0;
    endfunction

    // Move every window one step; ping-pong flips all groups together
    function automatic void advance_windows();
        int  ng, win, mv, nx, top;
        bit  flip;
        ng   = groups_eff();
        win  = int'(window_r);
        mv   = move_eff();
        flip = 1'b0;
        if (mode_r == gcsg_pkg::MODE_PINGPONG)
        begin
            for (int g = 0; g < ng; g++)
            begin
                nx  = head_pos[g] + head_dir[g] * mv;
                top = seg_base[g] + seg_len - win;
                if (nx < seg_base[g] || nx > top)
                    flip = 1'b1;
            end
            if (flip)
                for (int g = 0; g < ng; g++)
                    head_dir[g] = -head_dir[g];
        end
        for (int g = 0; g < ng; g++)
            head_pos[g] += head_dir[g] * mv;
    endfunction

    // Expected step for one accepted tick
    function automatic void predict_tick(bit restart);
        int           n, ng, win;
        chaser_step_t res;
        if (restart)
            reload_windows();
        n   = fixtures_eff();
        ng  = groups_eff();
        win = int'(window_r);
        res.mask = '0;
        for (int g = 0; g < ng; g++)
            for (int i = 0; i < n; i++)
                if (i >= head_pos[g] && i < head_pos[g] + win)
                    res.mask[i] = 1'b1;
        res.step = gcsg_pkg::STEP_W'(step_cnt);
        res.last = (step_cnt == seq_len - 1);
        step_expected = {step_expected, res};
        if (res.last)
            reload_windows();
        else
        begin
            advance_windows();
            step_cnt++;
        end
    endfunction

    // Register write as seen by the predictor; unknown indexes are dropped
    function automatic void apply_register(gcsg_pkg::cfg_index_t idx,
                                           logic [gcsg_pkg::CFG_DATA_W-1:0] val);
        bit known;
        known = 1'b1;
        case (idx)
            gcsg_pkg::REG_FIXTURE_COUNT: fixture_count_r = val;
            gcsg_pkg::REG_GROUP_COUNT:   group_count_r   = val[gcsg_pkg::GROUP_CFG_W-1:0];
            gcsg_pkg::REG_WINDOW_SIZE:   window_r        = val;
            gcsg_pkg::REG_MOVE_SIZE:     move_r          = val;
            gcsg_pkg::REG_MOTION_MODE:   mode_r          = val[gcsg_pkg::MODE_W-1:0];
            gcsg_pkg::REG_PARITY_BLOCK:  parity_r        = val[gcsg_pkg::PARITY_W-1:0];
            default:                     known = 1'b0;
        endcase
        if (known)
            reload_windows();
    endfunction

    function automatic void check_field(string name, logic [gcsg_pkg::MASK_W-1:0] exp_v,
                                        logic [gcsg_pkg::MASK_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endfunction

    // Tick driver: drives ticks from the pending queue, predicts on each transaction
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_tick(s_axis_tdata[0]);
                ticks_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tick_queue.size() > 0 && $urandom_range(99) >= gap_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(gcsg_pkg::IN_TDATA_W-1){1'b0}},
                                      tick_queue.pop_front()};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Step monitor: checks each transaction, drives random and long stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (step_expected.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected step, expected none, actual %h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    check_field("lit_mask", step_expected[0].mask,
                                m_axis_tdata[gcsg_pkg::MASK_W-1:0]);
                    check_field("step_index", gcsg_pkg::MASK_W'(step_expected[0].step),
                                gcsg_pkg::MASK_W'(m_axis_tdata[gcsg_pkg::MASK_W +:
                                                               gcsg_pkg::STEP_W]));
                    check_field("last_step", gcsg_pkg::MASK_W'(step_expected[0].last),
                                gcsg_pkg::MASK_W'(m_axis_tlast));
                    void'(step_expected.pop_front());
                end
            end
            if (hold_left == 0 && holds_served < hold_requests)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= gap_pct);
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk) cycle_count++;
        $display("** grouped_chaser_step_generator_unit: FAILED **");
        $finish;
    end

    task automatic queue_tick(bit restart);
        tick_queue = {tick_queue, restart};
        ticks_pushed++;
    endtask

    // Wait until every tick is taken and every step has come back
    task automatic wait_idle();
        while (ticks_accepted != ticks_pushed || step_expected.size() != 0)
            @(posedge clk);
    endtask

    // One register write; valid stays high for a following write
    task automatic write_register(gcsg_pkg::cfg_index_t idx,
                                  logic [gcsg_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(idx, val);
    endtask

    task automatic set_all(logic [6:0] fix, logic [6:0] grp, logic [6:0] win,
                           logic [6:0] mv, logic [6:0] mode, logic [6:0] pb);
        write_register(gcsg_pkg::REG_FIXTURE_COUNT, fix);
        write_register(gcsg_pkg::REG_GROUP_COUNT, grp);
        write_register(gcsg_pkg::REG_WINDOW_SIZE, win);
        write_register(gcsg_pkg::REG_MOVE_SIZE, mv);
        write_register(gcsg_pkg::REG_MOTION_MODE, mode);
        write_register(gcsg_pkg::REG_PARITY_BLOCK, pb);
        cfg_valid <= 1'b0;
    endtask

    // Main sequence
    initial
    begin
        int random_ticks;
        int phase;
        int count;
        random_ticks = 0;
        phase = 0;
        reload_windows();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration, restart in the middle
        queue_tick(1'b0);
        queue_tick(1'b0);
        queue_tick(1'b1);
        queue_tick(1'b0);
        wait_idle();

        // clamped fixtures, zero groups, zero move: full mask, one-step sequence
        set_all(7'd127, 7'd0, 7'd64, 7'd0, 7'(gcsg_pkg::MODE_FORWARD), 7'd0);
        queue_tick(1'b0);
        queue_tick(1'b1);
        wait_idle();

        // clamped groups, window wider than segment, running backward
        set_all(7'd64, 7'd31, 7'd7, 7'd1, 7'(gcsg_pkg::MODE_BACKWARD), 7'd0);
        queue_tick(1'b0);
        queue_tick(1'b0);
        wait_idle();

        // empty strip
        set_all(7'd0, 7'd3, 7'd2, 7'd1, 7'(gcsg_pkg::MODE_FORWARD), 7'd0);
        queue_tick(1'b0);
        queue_tick(1'b0);
        wait_idle();

        // mode code three, zero window, parity above group count
        set_all(7'd20, 7'd4, 7'd0, 7'd2, 7'd3, 7'd31);
        queue_tick(1'b0);
        queue_tick(1'b0);
        wait_idle();

        // ping-pong with alternating single-group blocks across a reversal
        set_all(7'd16, 7'd4, 7'd2, 7'd1, 7'(gcsg_pkg::MODE_PINGPONG), 7'd1);
        repeat (5) queue_tick(1'b0);
        wait_idle();

        // writes to unknown indexes change nothing
        write_register(gcsg_pkg::NUM_REGS, 7'd5);
        write_register(gcsg_pkg::cfg_index_t'(gcsg_pkg::NUM_REGS + 1), 7'd127);
        write_register(gcsg_pkg::REG_PARITY_BLOCK, 7'd2);
        cfg_valid <= 1'b0;
        queue_tick(1'b0);
        queue_tick(1'b1);
        queue_tick(1'b0);
        wait_idle();

        // random configurations, each followed by a run of ticks
        while (random_ticks < RANDOM_TICKS)
        begin
            wait_idle();
            gap_pct = (phase == 2) ? 0 : 10;
            set_all(($urandom_range(9) == 0) ? 7'($urandom_range(0, 127))
                                             : 7'($urandom_range(1, MAX_FIX)),
                    ($urandom_range(9) == 0) ? 7'($urandom_range(0, 127))
                                             : 7'($urandom_range(1, MAX_GRP)),
                    ($urandom_range(9) < 2)  ? 7'($urandom_range(0, 127))
                                             : 7'($urandom_range(1, 8)),
                    ($urandom_range(9) < 2)  ? 7'($urandom_range(0, 127))
                                             : 7'($urandom_range(1, 6)),
                    7'($urandom_range(0, 127)),
                    ($urandom_range(9) < 3)  ? 7'($urandom_range(0, 127))
                                             : 7'($urandom_range(0, 4)));
            count = (phase == 4) ? 110 : $urandom_range(40, 110);
            for (int i = 0; i < count; i++)
                queue_tick($urandom_range(99) < 4);
            random_ticks += count;
            // long output stall while ticks keep coming
            if (phase == 4)
                hold_requests++;
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("** grouped_chaser_step_generator_unit: PASSED **");
        else
            $display("** grouped_chaser_step_generator_unit: FAILED **");
        $finish;
    end

endmodule
